// File: rtl/mrfc_pkg.sv
package mrfc_pkg;

  localparam int unsigned MIN_FRAME_BYTES = 8;
  localparam int unsigned SEEN_W          = 4;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned QUEUE_PTR_W     = 1;
  localparam int unsigned QUEUE_CNT_W     = 2;

  localparam logic [SEEN_W-1:0] SEEN_MAX   = SEEN_W'(MIN_FRAME_BYTES);
  localparam logic [SEEN_W-1:0] SEEN_SHORT = SEEN_W'(MIN_FRAME_BYTES - 1);
  localparam logic [SEEN_W-1:0] SEEN_HDR0  = SEEN_W'(0);
  localparam logic [SEEN_W-1:0] SEEN_HDR1  = SEEN_W'(1);
  localparam logic [SEEN_W-1:0] SEEN_STAT0 = SEEN_W'(2);
  localparam logic [SEEN_W-1:0] SEEN_STAT3 = SEEN_W'(5);

  localparam logic [7:0]  HDR_FIRST      = 8'hEB;
  localparam logic [7:0]  HDR_FIRST_STOP = 8'hEF;
  localparam logic [7:0]  HDR_SECOND     = 8'h90;
  localparam logic [31:0] MASK_STOP      = 32'h0000_000F;
  localparam logic [31:0] MASK_MOTION    = 32'h0001_FFFF;

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned OUT_USER_W = 1;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_INCR  = 2'd1,
    KIND_POS   = 2'd2,
    KIND_STOP  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    RES_OK        = 3'd0,
    RES_EMPTY     = 3'd1,
    RES_SHORT     = 3'd2,
    RES_HDR_BAD   = 3'd3,
    RES_CKSUM_BAD = 3'd4,
    RES_DESYNC    = 3'd5,
    RES_REJECTED  = 3'd6
  } result_e;

  typedef struct packed {
    logic        empty;
    kind_e       kind;
    logic        too_short;
    logic [7:0]  hdr_first;
    logic [7:0]  hdr_second;
    logic [31:0] status_bytes;
    logic [15:0] run_sum;
    logic [7:0]  prev_byte;
    logic [7:0]  last_byte;
  } frame_rec_t;

  typedef struct packed {
    result_e     code;
    logic [31:0] status;
    logic        big_endian;
    logic [15:0] exp_sum;
    logic [15:0] rcv_sum;
  } verdict_t;

  function automatic logic [31:0] swap32(input logic [31:0] v);
    swap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

// File: rtl/mrfc_front.sv
module mrfc_front import mrfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  input  logic       empty_i,
  input  logic       last_i,
  input  kind_e      kind_i,
  output logic       push_o,
  output frame_rec_t rec_o
);

  logic [SEEN_W-1:0] seen_q, seen_d;
  logic [7:0]        hdr0_q, hdr0_d;
  logic [7:0]        hdr1_q, hdr1_d;
  logic [31:0]       stat_q, stat_d;
  logic [15:0]       sum_q, sum_d;
  logic [7:0]        prev_q, prev_d;
  logic              frame_end;

  assign frame_end = empty_i | last_i;
  assign push_o    = accept_i & frame_end;

  always_comb begin
    rec_o.empty        = empty_i;
    rec_o.kind         = kind_i;
    rec_o.too_short    = seen_q < SEEN_SHORT;
    rec_o.hdr_first    = hdr0_q;
    rec_o.hdr_second   = hdr1_q;
    rec_o.status_bytes = stat_q;
    rec_o.run_sum      = sum_q;
    rec_o.prev_byte    = prev_q;
    rec_o.last_byte    = byte_i;
  end

  always_comb begin
    seen_d = seen_q;
    hdr0_d = hdr0_q;
    hdr1_d = hdr1_q;
    stat_d = stat_q;
    sum_d  = sum_q;
    prev_d = prev_q;
    if (accept_i) begin
      if (frame_end) begin
        seen_d = '0;
        hdr0_d = '0;
        hdr1_d = '0;
        stat_d = '0;
        sum_d  = '0;
        prev_d = '0;
      end else begin
        if (seen_q == SEEN_HDR0) hdr0_d = byte_i;
        if (seen_q == SEEN_HDR1) hdr1_d = byte_i;
        if (seen_q >= SEEN_STAT0 && seen_q <= SEEN_STAT3) stat_d = {stat_q[23:0], byte_i};
        if (seen_q != SEEN_HDR0) sum_d = sum_q + {8'd0, prev_q};
        prev_d = byte_i;
        if (seen_q < SEEN_MAX) seen_d = seen_q + SEEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      hdr0_q <= '0;
      hdr1_q <= '0;
      stat_q <= '0;
      sum_q  <= '0;
      prev_q <= '0;
    end else begin
      seen_q <= seen_d;
      hdr0_q <= hdr0_d;
      hdr1_q <= hdr1_d;
      stat_q <= stat_d;
      sum_q  <= sum_d;
      prev_q <= prev_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= SEEN_MAX)
    else $error("byte count beyond saturation");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (seen_q == '0 && sum_q == '0 && prev_q == '0))
    else $error("frame state not cleared after frame end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !frame_end) |=> (prev_q == $past(byte_i)))
    else $error("previous byte not captured");

endmodule

// File: rtl/mrfc_fifo.sv
module mrfc_fifo import mrfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  frame_rec_t rec_i,
  output logic       full_o,
  output logic       valid_o,
  input  logic       pop_i,
  output frame_rec_t rec_o
);

  frame_rec_t             mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_q, wr_d;
  logic [QUEUE_PTR_W-1:0] rd_q, rd_d;
  logic [QUEUE_CNT_W-1:0] cnt_q, cnt_d;
  logic                   do_push, do_pop;

  assign full_o  = cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;
  assign rec_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + QUEUE_PTR_W'(1) : wr_q;
    rd_d  = do_pop ? rd_q + QUEUE_PTR_W'(1) : rd_q;
    cnt_d = cnt_q + QUEUE_CNT_W'(do_push) - QUEUE_CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= rec_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("queue count overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("request pushed into full queue");

endmodule

// File: rtl/mrfc_back.sv
module mrfc_back import mrfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  frame_rec_t rec_i,
  output logic       pop_o,
  output logic       valid_o,
  input  logic       ready_i,
  output verdict_t   verdict_o
);

  verdict_t    res;
  verdict_t    res_q;
  logic        valid_q, valid_d;
  logic        load;
  logic [31:0] be, le, mask, status;
  logic        big, hdr_ok;
  logic [15:0] rcv;

  always_comb begin
    be     = rec_i.status_bytes;
    le     = swap32(be);
    mask   = (rec_i.kind == KIND_STOP) ? MASK_STOP : MASK_MOTION;
    rcv    = {rec_i.last_byte, rec_i.prev_byte};
    hdr_ok = rec_i.hdr_second == HDR_SECOND &&
             (rec_i.hdr_first == HDR_FIRST ||
              (rec_i.kind == KIND_STOP && rec_i.hdr_first == HDR_FIRST_STOP));
    if (rec_i.kind == KIND_POS ||
        ((le & ~mask) != '0 && (be & mask) != '0 && (be & ~mask) == '0)) begin
      big    = 1'b1;
      status = be;
    end else begin
      big    = 1'b0;
      status = le;
    end
    res = '{code: RES_OK, status: '0, big_endian: 1'b0, exp_sum: '0, rcv_sum: '0};
    priority if (rec_i.empty) begin
      res.code = RES_EMPTY;
    end else if (rec_i.kind == KIND_OTHER) begin
      res.code = RES_OK;
    end else if (rec_i.too_short) begin
      res.code = RES_SHORT;
    end else if (!hdr_ok) begin
      res.code = RES_HDR_BAD;
    end else begin
      res.exp_sum = rec_i.run_sum;
      res.rcv_sum = rcv;
      if (rec_i.run_sum != rcv) begin
        res.code = RES_CKSUM_BAD;
      end else begin
        res.status     = status;
        res.big_endian = big;
        if ((status & ~mask) != '0) res.code = RES_DESYNC;
        else if (status != '0) res.code = RES_REJECTED;
        else res.code = RES_OK;
      end
    end
  end

  assign load      = valid_i & (~valid_q | ready_i);
  assign pop_o     = load;
  assign valid_o   = valid_q;
  assign verdict_o = res_q;

  always_comb begin
    valid_d = valid_q;
    if (load) valid_d = 1'b1;
    else if (ready_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (load) res_q <= res;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> valid_o)
    else $error("loaded verdict not presented");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && res_q.big_endian) |->
      (res_q.code == RES_OK || res_q.code == RES_DESYNC || res_q.code == RES_REJECTED))
    else $error("endianness flagged without status evaluation");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (res_q.code == RES_EMPTY || res_q.code == RES_SHORT ||
                 res_q.code == RES_HDR_BAD)) |->
      (res_q.exp_sum == '0 && res_q.rcv_sum == '0 && res_q.status == '0))
    else $error("checksum fields set on early failure");

endmodule

// File: rtl/motion_response_frame_checker.sv
// Takes one response byte per cycle while the queue has room, with no gaps
// needed between frames. Bytes fold into a running sum and a few header and
// status captures; the item that ends a frame (last mark or empty mark) pushes
// a frame record into a two-entry queue, and the verdict stage evaluates the
// record and holds it in an output register. The verdict reaches the output
// through the queue write and then the verdict register. Input is stalled only
// while both queue entries are occupied, which takes a stalled output; the
// stall ends in the cycle after the held verdict is taken.
module motion_response_frame_checker import mrfc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,   // byte_value
  input  logic                  s_axis_tlast_i,   // last_byte
  input  logic [IN_USER_W-1:0]  s_axis_tuser_i,   // empty_frame, command_kind
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,   // result_code, status_value,
                                                  // expected_sum, received_sum, zero pad
  output logic [OUT_USER_W-1:0] m_axis_tuser_o    // status_big_endian
);

  logic       accept, push, full, q_valid, pop;
  frame_rec_t rec_in, rec_out;
  verdict_t   verdict;

  assign s_axis_tready_o = ~full;
  assign accept          = s_axis_tvalid_i & ~full;

  mrfc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata_i[7:0]),
    .empty_i  (s_axis_tuser_i[0]),
    .last_i   (s_axis_tlast_i),
    .kind_i   (kind_e'(s_axis_tuser_i[2:1])),
    .push_o   (push),
    .rec_o    (rec_in)
  );

  mrfc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (rec_in),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .rec_o   (rec_out)
  );

  mrfc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (q_valid),
    .rec_i     (rec_out),
    .pop_o     (pop),
    .valid_o   (m_axis_tvalid_o),
    .ready_i   (m_axis_tready_i),
    .verdict_o (verdict)
  );

  assign m_axis_tdata_o = {5'd0, verdict.rcv_sum, verdict.exp_sum, verdict.status,
                           verdict.code};
  assign m_axis_tuser_o = verdict.big_endian;

endmodule

// File: sim/tb_motion_response_frame_checker.sv
`timescale 1ns / 1ps

module tb_motion_response_frame_checker;
  import mrfc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES    = 250;
  localparam int unsigned RANDOM_ITEMS   = 1200;
  localparam int unsigned DRAIN_CYCLES   = 16;

  typedef struct {
    result_e     code;
    logic [31:0] status;
    logic        big;
    logic [15:0] exp_sum;
    logic [15:0] rcv_sum;
  } verdict_exp_t;

  typedef enum int {
    SHAPE_GOOD,
    SHAPE_BAD_SUM,
    SHAPE_BAD_HDR,
    SHAPE_SHORT,
    SHAPE_NOISE,
    SHAPE_ABORT,
    SHAPE_EMPTY
  } frame_shape_e;

  class verdict_scoreboard;
    verdict_exp_t verdicts_due[$];
    int           errors;
    logic [3:0]   seen;
    logic [7:0]   hdr0;
    logic [7:0]   hdr1;
    logic [7:0]   prev;
    logic [31:0]  stat;
    logic [15:0]  sum;

    function new();
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      seen = '0;
      hdr0 = '0;
      hdr1 = '0;
      prev = '0;
      stat = '0;
      sum  = '0;
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction

    function void take_request(logic [7:0] b, logic empty, logic last, kind_e kind);
      verdict_exp_t v;
      logic [31:0]  be;
      logic [31:0]  le;
      logic [31:0]  mask;
      v = '{code: RES_OK, status: '0, big: 1'b0, exp_sum: '0, rcv_sum: '0};
      if (empty) begin
        clear_frame();
        v.code = RES_EMPTY;
        verdicts_due.insert(verdicts_due.size(), v);
        return;
      end
      if (!last) begin
        if (seen == 4'd0) hdr0 = b;
        else if (seen == 4'd1) hdr1 = b;
        if (seen >= 4'd2 && seen <= 4'd5) stat = {stat[23:0], b};
        if (seen != 4'd0) sum = sum + 16'(prev);
        prev = b;
        if (seen < MIN_FRAME_BYTES) seen = seen + 4'd1;
        return;
      end
      if (kind != KIND_OTHER) begin
        if (int'(seen) + 1 < int'(MIN_FRAME_BYTES)) begin
          v.code = RES_SHORT;
        end else if (!(hdr1 == HDR_SECOND &&
                       (hdr0 == HDR_FIRST || (kind == KIND_STOP && hdr0 == HDR_FIRST_STOP)))) begin
          v.code = RES_HDR_BAD;
        end else begin
          v.exp_sum = sum;
          v.rcv_sum = {b, prev};
          if (v.exp_sum != v.rcv_sum) begin
            v.code = RES_CKSUM_BAD;
          end else begin
            be   = stat;
            le   = {stat[7:0], stat[15:8], stat[23:16], stat[31:24]};
            mask = (kind == KIND_STOP) ? MASK_STOP : MASK_MOTION;
            if (kind == KIND_POS ||
                ((le & ~mask) != 0 && (be & mask) != 0 && (be & ~mask) == 0)) begin
              v.status = be;
              v.big    = 1'b1;
            end else begin
              v.status = le;
              v.big    = 1'b0;
            end
            if ((v.status & ~mask) != 0) v.code = RES_DESYNC;
            else if (v.status != 0) v.code = RES_REJECTED;
            else v.code = RES_OK;
          end
        end
      end
      clear_frame();
      verdicts_due.insert(verdicts_due.size(), v);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t ERROR %s: expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_verdict(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
      verdict_exp_t v;
      if (verdicts_due.size() == 0) begin
        $display("%0t ERROR verdict: expected none actual %0h/%0h", $time, data, user);
        errors++;
        return;
      end
      v = verdicts_due.pop_front();
      compare_field("result_code", 32'(v.code), 32'(data[2:0]));
      compare_field("status_value", v.status, data[34:3]);
      compare_field("expected_sum", 32'(v.exp_sum), 32'(data[50:35]));
      compare_field("received_sum", 32'(v.rcv_sum), 32'(data[66:51]));
      compare_field("tdata_pad", 32'd0, 32'(data[OUT_DATA_W-1:67]));
      compare_field("status_big_endian", 32'(v.big), 32'(user[0]));
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;

  verdict_scoreboard sb = new();
  logic [7:0]        frame_q[$];
  int                items_sent = 0;
  int                src_mode = 0;
  int                sink_mode = 0;
  bit                hold_req = 1'b0;

  always #2 clk_i = ~clk_i;

  motion_response_frame_checker u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  task automatic send_item(logic [7:0] b, logic empty, logic last, kind_e kind);
    int gap;
    int r;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    s_axis_tuser  <= {kind, empty};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_request(b, empty, last, kind);
    items_sent++;
    gap = 0;
    if (src_mode != 0) begin
      r = $urandom_range(0, 99);
      if (r >= 95) gap = $urandom_range(10, 40);
      else if (r >= 70) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_frame(kind_e kind);
    int n;
    n = frame_q.size();
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) send_item(frame_q[i], 1'b0, 1'b1, kind);
      else send_item(frame_q[i], 1'b0, 1'b0, kind_e'($urandom_range(0, 3)));
    end
  endtask

  function automatic void add_byte(logic [7:0] b);
    frame_q.insert(frame_q.size(), b);
  endfunction

  function automatic void fill_frame(logic [7:0] first, logic [31:0] st, bit big, int len);
    logic [15:0] total;
    frame_q.delete();
    add_byte(first);
    add_byte(HDR_SECOND);
    if (big) begin
      add_byte(st[31:24]);
      add_byte(st[23:16]);
      add_byte(st[15:8]);
      add_byte(st[7:0]);
    end else begin
      add_byte(st[7:0]);
      add_byte(st[15:8]);
      add_byte(st[23:16]);
      add_byte(st[31:24]);
    end
    for (int i = 6; i < len - 2; i++) add_byte(8'($urandom_range(0, 255)));
    total = '0;
    foreach (frame_q[i]) total = total + 16'(frame_q[i]);
    add_byte(total[7:0]);
    add_byte(total[15:8]);
  endfunction

  task automatic send_random_frame();
    frame_shape_e shape;
    kind_e        kind;
    logic [31:0]  mask;
    logic [31:0]  st;
    logic [7:0]   first;
    int           r;
    int           len;
    int           idx;
    r = $urandom_range(0, 99);
    if (r < 62) shape = SHAPE_GOOD;
    else if (r < 70) shape = SHAPE_BAD_SUM;
    else if (r < 77) shape = SHAPE_BAD_HDR;
    else if (r < 84) shape = SHAPE_SHORT;
    else if (r < 90) shape = SHAPE_NOISE;
    else if (r < 95) shape = SHAPE_ABORT;
    else shape = SHAPE_EMPTY;
    kind = ($urandom_range(0, 9) == 0) ? KIND_OTHER : kind_e'($urandom_range(1, 3));
    case (shape)
      SHAPE_EMPTY: begin
        send_item(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)), kind);
      end
      SHAPE_SHORT, SHAPE_NOISE, SHAPE_ABORT: begin
        len = (shape == SHAPE_SHORT) ? $urandom_range(1, 7) : $urandom_range(1, 20);
        frame_q.delete();
        if (shape == SHAPE_SHORT && $urandom_range(0, 1) == 1) begin
          add_byte(HDR_FIRST);
          add_byte(HDR_SECOND);
        end
        while (frame_q.size() < len) add_byte(8'($urandom_range(0, 255)));
        if (shape == SHAPE_ABORT) begin
          foreach (frame_q[i]) send_item(frame_q[i], 1'b0, 1'b0, kind_e'($urandom_range(0, 3)));
          send_item(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1)), kind);
        end else begin
          send_frame(kind);
        end
      end
      default: begin
        mask = (kind == KIND_STOP) ? MASK_STOP : MASK_MOTION;
        r = $urandom_range(0, 99);
        if (r < 25) st = '0;
        else if (r < 50) st = $urandom() & mask;
        else if (r < 70) st = 32'd1 << $urandom_range(0, 31);
        else if (r < 85) st = $urandom();
        else st = $urandom() & ((kind == KIND_STOP) ? MASK_MOTION : MASK_STOP);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 24) : $urandom_range(8, 12);
        first = (kind == KIND_STOP && $urandom_range(0, 1) == 1) ? HDR_FIRST_STOP : HDR_FIRST;
        fill_frame(first, st, 1'($urandom_range(0, 1)), len);
        if (shape == SHAPE_BAD_HDR) begin
          idx = $urandom_range(0, 1);
          frame_q[idx] = frame_q[idx] ^ 8'($urandom_range(1, 255));
        end else if (shape == SHAPE_BAD_SUM) begin
          idx = $urandom_range(2, frame_q.size() - 1);
          frame_q[idx] = frame_q[idx] ^ (8'd1 << $urandom_range(0, 7));
        end
        send_frame(kind);
      end
    endcase
  endtask

  initial begin : sink
    int stall_left;
    int r;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (sink_mode != 0) begin
          r = $urandom_range(0, 99);
          if (r >= 97) stall_left = $urandom_range(20, 60);
          else if (r >= 75) stall_left = $urandom_range(1, 3);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_verdict(m_axis_tdata, m_axis_tuser);
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle = 0;
      else idle++;
      if (idle >= WATCHDOG_LIMIT) begin
        $display("%0t ERROR watchdog: no handshake for %0d cycles", $time, idle);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_item(8'h00, 1'b1, 1'b0, KIND_OTHER);
    send_item(8'hFF, 1'b1, 1'b1, KIND_INCR);
    send_item(8'hA5, 1'b1, 1'b0, KIND_POS);
    send_item(8'h5A, 1'b1, 1'b1, KIND_STOP);
    send_item(8'hFF, 1'b0, 1'b1, KIND_INCR);
    send_item(HDR_FIRST, 1'b0, 1'b0, KIND_POS);
    send_item(HDR_SECOND, 1'b0, 1'b0, KIND_POS);
    send_item(8'hFF, 1'b1, 1'b0, KIND_POS);
    send_item(8'h00, 1'b0, 1'b1, KIND_OTHER);
    fill_frame(HDR_FIRST_STOP, 32'd0, 1'b0, 8);
    send_frame(KIND_STOP);
    fill_frame(HDR_FIRST, 32'hFFFF_FFFF, 1'b0, 8);
    send_frame(KIND_INCR);

    src_mode  = 0;
    sink_mode = 0;
    hold_req  = 1'b1;
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent % 100 < 3) begin
        src_mode  = $urandom_range(0, 2);
        sink_mode = $urandom_range(0, 2);
      end
      if (items_sent > RANDOM_ITEMS / 2 && items_sent < RANDOM_ITEMS / 2 + 4) begin
        src_mode = 0;
        hold_req = 1'b1;
      end
      send_random_frame();
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: motion_response_frame_checker.f
rtl/mrfc_pkg.sv
rtl/mrfc_front.sv
rtl/mrfc_fifo.sv
rtl/mrfc_back.sv
rtl/motion_response_frame_checker.sv
sim/tb_motion_response_frame_checker.sv
